// ===== sv/lbps_pkg.sv =====
// Shared types and codes for the LED blink pattern sequencer.
// No dependencies; imported by every module of the block but lbps_ms2tick.
package lbps_pkg;

    // Command codes carried in the mode field
    localparam logic [3:0] MODE_TICK         = 4'd0;
    localparam logic [3:0] MODE_ON           = 4'd1;
    localparam logic [3:0] MODE_OFF          = 4'd2;
    localparam logic [3:0] MODE_TOGGLE       = 4'd3;
    localparam logic [3:0] MODE_ON_TIME      = 4'd4;
    localparam logic [3:0] MODE_BLINK        = 4'd5;
    localparam logic [3:0] MODE_REPEAT       = 4'd6;
    localparam logic [3:0] MODE_ENDLESS      = 4'd7;
    localparam logic [3:0] MODE_STOP_ENDLESS = 4'd8;
    localparam logic [3:0] MODE_STOP_LED     = 4'd9;
    localparam logic [3:0] MODE_STOP_ALL     = 4'd10;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_LED = 2'd1;
    localparam logic [1:0] ST_PERIOD = 2'd2;
    localparam logic [1:0] ST_SPEED  = 2'd3;

    // Bit positions in the per-LED process flags
    localparam int F_ON    = 0;
    localparam int F_BLINK = 1;
    localparam int F_REP   = 2;
    localparam int F_INF   = 3;

    typedef struct packed {
        logic [3:0]  mode;
        logic [1:0]  led_index;
        logic [15:0] on_ms;
        logic [15:0] blink_period_ms;
        logic [7:0]  blink_count;
        logic [15:0] repeat_period_ms;
        logic [7:0]  repeat_count;
        logic [7:0]  toggle_ticks;
    } in_item_t;

    typedef struct packed {
        logic [2:0] led_levels;
        logic [1:0] status;
    } out_item_t;

    // Command after period conversion
    typedef struct packed {
        in_item_t    item;
        logic [15:0] on_q;
        logic [15:0] bper_q;
        logic [15:0] rper_q;
    } work_t;

    // Update strobe and command check result, broadcast to every LED
    typedef struct packed {
        logic go;
        logic cmd_ok;
    } led_ctl_t;

endpackage

// ===== sv/lbps_ms2tick.sv =====
// Millisecond to tick conversion: 16-bit value divided by TICK_MS.
// Reciprocal multiply, exact for every 16-bit input. No dependencies.
module lbps_ms2tick #(
    parameter int TICK_MS = 1
) (
    input  logic [15:0] ms,
    output logic [15:0] ticks
);
    localparam int SHIFT = 16 + $clog2(TICK_MS);
    localparam logic [16:0] RECIP = 17'(((64'd1 << SHIFT) / TICK_MS) + 64'd1);

    logic [47:0] prod;

    assign prod  = 48'(ms) * 48'(RECIP);
    assign ticks = prod[SHIFT +: 16];

endmodule

// ===== sv/lbps_led.sv =====
// Per-LED pattern state: on-time, blink, repetition and endless toggle processes.
// Depends on lbps_pkg.
module lbps_led #(
    parameter int IDX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  lbps_pkg::led_ctl_t ctl,
    input  lbps_pkg::work_t  work,
    output logic             lit_next
);
    import lbps_pkg::*;

    typedef struct packed {
        logic        lit;
        logic [3:0]  flags;
        logic [15:0] on_ms;
        logic [15:0] on_q;
        logic [15:0] on_limit;
        logic [15:0] on_cnt;
        logic [15:0] bper;
        logic [15:0] bper_q;
        logic [7:0]  bcount;
        logic [15:0] blimit;
        logic [15:0] btick;
        logic [7:0]  bdone;
        logic [7:0]  rcount;
        logic [15:0] rlimit;
        logic [15:0] rtick;
        logic [7:0]  rdone;
        logic [7:0]  tlimit;
        logic [7:0]  ttick;
    } led_st_t;

    led_st_t st_reg, st_next;
    logic    target;

    assign target   = (int'(work.item.led_index) == IDX);
    assign lit_next = st_next.lit;

    always_comb begin
        led_st_t s;
        s = st_reg;
        if (ctl.go) begin
            if (work.item.mode == MODE_TICK) begin
                // endless toggle
                if (s.flags[F_INF]) begin
                    if (s.ttick == 8'd0) begin
                        s.lit = ~s.lit;
                    end else if (s.ttick == s.tlimit) begin
                        s.ttick = 8'd0;
                        s.lit   = ~s.lit;
                    end
                    s.ttick = s.ttick + 8'd1;
                end
                // repetition: restarts the blink process, skipped if checks fail
                if (s.flags[F_REP]) begin
                    if (s.rtick == 16'd0) begin
                        if (!(s.on_ms > s.bper) && s.bper_q != 16'd0) begin
                            s.bdone          = 8'd0;
                            s.blimit         = s.bper_q;
                            s.btick          = 16'd0;
                            s.flags[F_BLINK] = 1'b1;
                        end
                    end else if (s.rtick == s.rlimit) begin
                        s.rtick = 16'd0;
                        s.rdone = s.rdone + 8'd1;
                        if (s.rdone == s.rcount) begin
                            s.flags[F_REP] = 1'b0;
                        end else if (!(s.on_ms > s.bper) && s.bper_q != 16'd0) begin
                            s.bdone          = 8'd0;
                            s.blimit         = s.bper_q;
                            s.btick          = 16'd0;
                            s.flags[F_BLINK] = 1'b1;
                        end
                    end
                    s.rtick = s.rtick + 16'd1;
                end
                // blink: restarts the on-time process
                if (s.flags[F_BLINK]) begin
                    if (s.btick == 16'd0) begin
                        if (s.on_q != 16'd0) begin
                            s.on_limit    = s.on_q;
                            s.on_cnt      = 16'd0;
                            s.flags[F_ON] = 1'b1;
                        end
                    end else if (s.btick == s.blimit) begin
                        s.btick = 16'd0;
                        s.bdone = s.bdone + 8'd1;
                        if (s.bdone == s.bcount) begin
                            s.flags[F_BLINK] = 1'b0;
                        end else if (s.on_q != 16'd0) begin
                            s.on_limit    = s.on_q;
                            s.on_cnt      = 16'd0;
                            s.flags[F_ON] = 1'b1;
                        end
                    end
                    s.btick = s.btick + 16'd1;
                end
                // one-shot on-time
                if (s.flags[F_ON]) begin
                    if (s.on_cnt == 16'd0) begin
                        s.lit = 1'b1;
                    end
                    if (s.on_cnt == s.on_limit) begin
                        s.flags[F_ON] = 1'b0;
                        s.on_cnt      = 16'd0;
                        s.lit         = 1'b0;
                    end
                    s.on_cnt = s.on_cnt + 16'd1;
                end
            end else if (work.item.mode == MODE_STOP_ALL) begin
                s = '0;
            end else if (ctl.cmd_ok && target) begin
                unique case (work.item.mode)
                    MODE_ON: begin
                        s.lit = 1'b1;
                    end
                    MODE_OFF: begin
                        s.lit = 1'b0;
                    end
                    MODE_TOGGLE: begin
                        s.lit = ~s.lit;
                    end
                    MODE_ON_TIME: begin
                        s.on_ms       = work.item.on_ms;
                        s.on_q        = work.on_q;
                        s.on_limit    = work.on_q;
                        s.on_cnt      = 16'd0;
                        s.flags[F_ON] = 1'b1;
                    end
                    MODE_BLINK: begin
                        s.bper           = work.item.blink_period_ms;
                        s.bper_q         = work.bper_q;
                        s.bcount         = work.item.blink_count;
                        s.bdone          = 8'd0;
                        s.blimit         = work.bper_q;
                        s.btick          = 16'd0;
                        s.on_ms          = work.item.on_ms;
                        s.on_q           = work.on_q;
                        s.flags[F_BLINK] = 1'b1;
                    end
                    MODE_REPEAT: begin
                        s.rcount       = work.item.repeat_count;
                        s.rdone        = 8'd0;
                        s.rlimit       = work.rper_q;
                        s.rtick        = 16'd0;
                        s.bper         = work.item.blink_period_ms;
                        s.bper_q       = work.bper_q;
                        s.bcount       = work.item.blink_count;
                        s.bdone        = 8'd0;
                        s.on_ms        = work.item.on_ms;
                        s.on_q         = work.on_q;
                        s.flags[F_REP] = 1'b1;
                    end
                    MODE_ENDLESS: begin
                        s.tlimit       = work.item.toggle_ticks;
                        s.ttick        = 8'd0;
                        s.flags[F_INF] = 1'b1;
                    end
                    MODE_STOP_ENDLESS: begin
                        s.flags[F_INF] = 1'b0;
                        s.tlimit       = 8'd0;
                        s.ttick        = 8'd0;
                        s.lit          = 1'b0;
                    end
                    MODE_STOP_LED: begin
                        s = '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        st_next = s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== sv/led_blink_pattern_sequencer.sv =====
// Top level of the LED blink pattern sequencer: input register, period
// conversion stage, per-LED update and result register. Uses lbps_pkg,
// lbps_ms2tick and lbps_led.
//
//  Channel  Ports                      Carries
//  input    s_valid s_ready s_data     one command or tick (in_item_t)
//  result   m_valid m_ready m_data     LED levels and status (out_item_t)
//
// One item per cycle sustained while m_ready keeps up; an item's result passes
// through the input register (loaded at the transfer), then the ms-to-tick
// register, then the result register.
// Each stage moves on when the stage after it is empty or moving, so input
// is still taken while a result waits, until all three stages are full.
// Reset (aresetn low, synchronous) empties the stages and turns all LEDs off.
module led_blink_pattern_sequencer #(
    parameter int TICK_MS   = 1,
    parameter int LED_COUNT = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lbps_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lbps_pkg::out_item_t   m_data
);
    import lbps_pkg::*;

    logic      a_valid_reg, a_valid_next;
    in_item_t  a_item_reg, a_item_next;
    logic      b_valid_reg, b_valid_next;
    work_t     b_work_reg, b_work_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    logic      out_ready, b_ready, a_fire, b_fire, s_fire;
    logic [15:0] on_q, bper_q, rper_q;
    logic [1:0]  status;
    logic        idx_valid;
    led_ctl_t    ctl;
    logic [LED_COUNT-1:0] lit_all;
    logic [2:0]  levels;

    assign out_ready = !m_valid_reg || m_ready;
    assign b_fire    = b_valid_reg && out_ready;
    assign b_ready   = !b_valid_reg || out_ready;
    assign a_fire    = a_valid_reg && b_ready;
    assign s_ready   = !a_valid_reg || b_ready;
    assign s_fire    = s_valid && s_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    lbps_ms2tick #(.TICK_MS(TICK_MS)) u_on_q (
        .ms    (a_item_reg.on_ms),
        .ticks (on_q)
    );

    lbps_ms2tick #(.TICK_MS(TICK_MS)) u_bper_q (
        .ms    (a_item_reg.blink_period_ms),
        .ticks (bper_q)
    );

    lbps_ms2tick #(.TICK_MS(TICK_MS)) u_rper_q (
        .ms    (a_item_reg.repeat_period_ms),
        .ticks (rper_q)
    );

    // Command checks depend only on the item, never on LED state
    assign idx_valid = (int'(b_work_reg.item.led_index) < LED_COUNT);

    always_comb begin
        status = ST_OK;
        if (b_work_reg.item.mode == MODE_ENDLESS && b_work_reg.item.toggle_ticks == 8'd0) begin
            status = ST_SPEED;
        end else if (b_work_reg.item.mode >= MODE_ON && b_work_reg.item.mode <= MODE_STOP_LED
                     && !idx_valid) begin
            status = ST_NO_LED;
        end else begin
            case (b_work_reg.item.mode)
                MODE_ON_TIME: begin
                    if (b_work_reg.on_q == 16'd0) status = ST_PERIOD;
                end
                MODE_BLINK: begin
                    if (b_work_reg.item.on_ms > b_work_reg.item.blink_period_ms
                        || b_work_reg.bper_q == 16'd0) status = ST_PERIOD;
                end
                MODE_REPEAT: begin
                    if (b_work_reg.item.blink_period_ms > b_work_reg.item.repeat_period_ms
                        || b_work_reg.item.on_ms > b_work_reg.item.blink_period_ms
                        || b_work_reg.rper_q == 16'd0) status = ST_PERIOD;
                end
                default: begin
                end
            endcase
        end
    end

    assign ctl.go     = b_fire;
    assign ctl.cmd_ok = (status == ST_OK);

    for (genvar i = 0; i < LED_COUNT; i++) begin : g_led
        lbps_led #(.IDX(i)) u_led (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .work     (b_work_reg),
            .lit_next (lit_all[i])
        );
    end

    // Only the first three LEDs are visible in the result
    for (genvar k = 0; k < 3; k++) begin : g_lvl
        if (k < LED_COUNT) begin : g_on
            assign levels[k] = lit_all[k];
        end else begin : g_off
            assign levels[k] = 1'b0;
        end
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        a_item_next  = a_item_reg;
        b_valid_next = b_valid_reg;
        b_work_next  = b_work_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (s_fire) begin
            a_valid_next = 1'b1;
            a_item_next  = s_data;
        end else if (a_fire) begin
            a_valid_next = 1'b0;
        end

        if (a_fire) begin
            b_valid_next       = 1'b1;
            b_work_next.item   = a_item_reg;
            b_work_next.on_q   = on_q;
            b_work_next.bper_q = bper_q;
            b_work_next.rper_q = rper_q;
        end else if (b_fire) begin
            b_valid_next = 1'b0;
        end

        if (b_fire) begin
            m_valid_next           = 1'b1;
            m_data_next.led_levels = levels;
            m_data_next.status     = status;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_item_reg <= a_item_next;
        b_work_reg <= b_work_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== tb/led_blink_pattern_sequencer_test.sv =====
// Self-checking testbench for led_blink_pattern_sequencer: a directed run, then
// random command and tick traffic with random idling on both channels.
// Depends on lbps_pkg and the block's RTL.
`timescale 1ns / 100ps

module led_blink_pattern_sequencer_test;
    import lbps_pkg::*;

    localparam int TICK_MS   = 1;
    localparam int LED_COUNT = 3;
    localparam int ITEM_GOAL = 1600;
    localparam int MAX_CYCLES = 1_000_000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    always #5 aclk = ~aclk;

    led_blink_pattern_sequencer #(
        .TICK_MS   (TICK_MS),
        .LED_COUNT (LED_COUNT)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    in_item_t  cmd_queue[$];
    out_item_t levels_due[$];
    int        items_queued = 0;
    int        mismatches = 0;
    int        send_gap = 0;
    int        rx_stall = 0;
    int        cycle_count = 0;
    bit        no_idle = 1'b0;

    // Per-LED pattern state
    bit        lit       [LED_COUNT];
    bit [3:0]  run_flags [LED_COUNT];
    bit [15:0] pulse_ms  [LED_COUNT];
    bit [15:0] pulse_lim [LED_COUNT];
    bit [15:0] pulse_cnt [LED_COUNT];
    bit [15:0] bl_per    [LED_COUNT];
    bit [7:0]  bl_cnt    [LED_COUNT];
    bit [15:0] bl_lim    [LED_COUNT];
    bit [15:0] bl_tick   [LED_COUNT];
    bit [7:0]  bl_done   [LED_COUNT];
    bit [7:0]  rp_cnt    [LED_COUNT];
    bit [15:0] rp_lim    [LED_COUNT];
    bit [15:0] rp_tick   [LED_COUNT];
    bit [7:0]  rp_done   [LED_COUNT];
    bit [7:0]  tg_lim    [LED_COUNT];
    bit [7:0]  tg_tick   [LED_COUNT];

    function automatic bit [15:0] ms_to_ticks(bit [15:0] ms);
        return ms / 16'(TICK_MS);
    endfunction

    function automatic bit [1:0] start_pulse(int i, bit [15:0] on);
        bit [15:0] q;
        q = ms_to_ticks(on);
        if (q == 0) return ST_PERIOD;
        pulse_ms[i] = on;
        pulse_lim[i] = q;
        pulse_cnt[i] = 0;
        run_flags[i][F_ON] = 1'b1;
        return ST_OK;
    endfunction

    function automatic bit [1:0] start_blink(int i, bit [7:0] cnt, bit [15:0] per,
                                             bit [15:0] on);
        bit [15:0] q;
        if (on > per) return ST_PERIOD;
        q = ms_to_ticks(per);
        if (q == 0) return ST_PERIOD;
        bl_per[i] = per;
        bl_cnt[i] = cnt;
        bl_done[i] = 0;
        bl_lim[i] = q;
        bl_tick[i] = 0;
        pulse_ms[i] = on;
        run_flags[i][F_BLINK] = 1'b1;
        return ST_OK;
    endfunction

    function automatic void clear_led(int i);
        run_flags[i] = 0;
        pulse_ms[i] = 0;
        pulse_lim[i] = 0;
        pulse_cnt[i] = 0;
        bl_per[i] = 0;
        bl_cnt[i] = 0;
        bl_lim[i] = 0;
        bl_tick[i] = 0;
        bl_done[i] = 0;
        rp_cnt[i] = 0;
        rp_lim[i] = 0;
        rp_tick[i] = 0;
        rp_done[i] = 0;
        tg_lim[i] = 0;
        tg_tick[i] = 0;
        lit[i] = 0;
    endfunction

    // Order matters: endless, repetition, blink, on-time. A process started
    // earlier in the same tick runs in that tick.
    function automatic void tick_led(int i);
        if (run_flags[i][F_INF]) begin
            if (tg_tick[i] == 0) begin
                lit[i] = ~lit[i];
            end else if (tg_tick[i] == tg_lim[i]) begin
                tg_tick[i] = 0;
                lit[i] = ~lit[i];
            end
            tg_tick[i] = tg_tick[i] + 8'd1;
        end
        if (run_flags[i][F_REP]) begin
            if (rp_tick[i] == 0) begin
                void'(start_blink(i, bl_cnt[i], bl_per[i], pulse_ms[i]));
            end else if (rp_tick[i] == rp_lim[i]) begin
                rp_tick[i] = 0;
                rp_done[i] = rp_done[i] + 8'd1;
                if (rp_done[i] == rp_cnt[i])
                    run_flags[i][F_REP] = 1'b0;
                else
                    void'(start_blink(i, bl_cnt[i], bl_per[i], pulse_ms[i]));
            end
            rp_tick[i] = rp_tick[i] + 16'd1;
        end
        if (run_flags[i][F_BLINK]) begin
            if (bl_tick[i] == 0) begin
                void'(start_pulse(i, pulse_ms[i]));
            end else if (bl_tick[i] == bl_lim[i]) begin
                bl_tick[i] = 0;
                bl_done[i] = bl_done[i] + 8'd1;
                if (bl_done[i] == bl_cnt[i])
                    run_flags[i][F_BLINK] = 1'b0;
                else
                    void'(start_pulse(i, pulse_ms[i]));
            end
            bl_tick[i] = bl_tick[i] + 16'd1;
        end
        if (run_flags[i][F_ON]) begin
            if (pulse_cnt[i] == 0) lit[i] = 1'b1;
            if (pulse_cnt[i] == pulse_lim[i]) begin
                run_flags[i][F_ON] = 1'b0;
                pulse_cnt[i] = 0;
                lit[i] = 1'b0;
            end
            pulse_cnt[i] = pulse_cnt[i] + 16'd1;
        end
    endfunction

    // Updates the LED state for one transfer and returns the expected result
    function automatic out_item_t apply_item(in_item_t it);
        out_item_t r;
        int idx;
        r = '0;
        r.status = ST_OK;
        idx = it.led_index;
        if (it.mode == MODE_TICK) begin
            for (int i = 0; i < LED_COUNT; i++) tick_led(i);
        end else if (it.mode == MODE_STOP_ALL) begin
            for (int i = 0; i < LED_COUNT; i++) clear_led(i);
        end else if (it.mode == MODE_ENDLESS && it.toggle_ticks == 0) begin
            r.status = ST_SPEED;
        end else if (it.mode >= MODE_ON && it.mode <= MODE_STOP_LED && idx >= LED_COUNT) begin
            r.status = ST_NO_LED;
        end else begin
            case (it.mode)
                MODE_ON:      lit[idx] = 1'b1;
                MODE_OFF:     lit[idx] = 1'b0;
                MODE_TOGGLE:  lit[idx] = ~lit[idx];
                MODE_ON_TIME: r.status = start_pulse(idx, it.on_ms);
                MODE_BLINK: begin
                    r.status = start_blink(idx, it.blink_count, it.blink_period_ms, it.on_ms);
                end
                MODE_REPEAT: begin
                    if (it.blink_period_ms > it.repeat_period_ms
                            || it.on_ms > it.blink_period_ms
                            || ms_to_ticks(it.repeat_period_ms) == 0) begin
                        r.status = ST_PERIOD;
                    end else begin
                        rp_cnt[idx] = it.repeat_count;
                        rp_done[idx] = 0;
                        rp_lim[idx] = ms_to_ticks(it.repeat_period_ms);
                        rp_tick[idx] = 0;
                        bl_per[idx] = it.blink_period_ms;
                        bl_cnt[idx] = it.blink_count;
                        bl_done[idx] = 0;
                        pulse_ms[idx] = it.on_ms;
                        run_flags[idx][F_REP] = 1'b1;
                    end
                end
                MODE_ENDLESS: begin
                    tg_lim[idx] = it.toggle_ticks;
                    tg_tick[idx] = 0;
                    run_flags[idx][F_INF] = 1'b1;
                end
                MODE_STOP_ENDLESS: begin
                    run_flags[idx][F_INF] = 1'b0;
                    tg_lim[idx] = 0;
                    tg_tick[idx] = 0;
                    lit[idx] = 1'b0;
                end
                MODE_STOP_LED: clear_led(idx);
                default: ;  // unused modes do nothing
            endcase
        end
        for (int i = 0; i < LED_COUNT && i < 3; i++) r.led_levels[i] = lit[i];
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_item_t noise_item();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return in_item_t'(raw[$bits(in_item_t)-1:0]);
    endfunction

    function automatic in_item_t cmd(logic [3:0] mode, logic [1:0] idx, logic [15:0] on,
                                     logic [15:0] bper, logic [7:0] bcnt,
                                     logic [15:0] rper, logic [7:0] rcnt, logic [7:0] tog);
        in_item_t it;
        it.mode = mode;
        it.led_index = idx;
        it.on_ms = on;
        it.blink_period_ms = bper;
        it.blink_count = bcnt;
        it.repeat_period_ms = rper;
        it.repeat_count = rcnt;
        it.toggle_ticks = tog;
        return it;
    endfunction

    function automatic logic [7:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 8'd0;
        if (r < 11) return 8'hFF;
        return 8'($urandom_range(1, 4));
    endfunction

    // Mostly well-formed commands with short periods so ticks get through them
    function automatic in_item_t rand_command();
        in_item_t it;
        int r;
        it = noise_item();
        if ($urandom_range(0, 99) < 15) return it;
        r = $urandom_range(0, 99);
        if (r < 4)       it.mode = MODE_STOP_ALL + 4'($urandom_range(1, 5));
        else if (r < 7)  it.mode = MODE_ON;
        else if (r < 10) it.mode = MODE_OFF;
        else if (r < 13) it.mode = MODE_TOGGLE;
        else if (r < 30) it.mode = MODE_ON_TIME;
        else if (r < 50) it.mode = MODE_BLINK;
        else if (r < 70) it.mode = MODE_REPEAT;
        else if (r < 82) it.mode = MODE_ENDLESS;
        else if (r < 88) it.mode = MODE_STOP_ENDLESS;
        else if (r < 95) it.mode = MODE_STOP_LED;
        else             it.mode = MODE_STOP_ALL;
        it.led_index = ($urandom_range(0, 99) < 8) ? 2'd3 : 2'($urandom_range(0, 2));
        it.on_ms = 16'($urandom_range(0, 5));
        it.blink_period_ms = it.on_ms + 16'($urandom_range(0, 6));
        it.repeat_period_ms = it.blink_period_ms + 16'($urandom_range(0, 12));
        it.blink_count = pick_count();
        it.repeat_count = pick_count();
        it.toggle_ticks = ($urandom_range(0, 99) < 5) ? 8'd0 : 8'($urandom_range(1, 9));
        r = $urandom_range(0, 99);
        if (r < 4)      it.on_ms = it.blink_period_ms + 16'd1;
        else if (r < 8) it.blink_period_ms = it.repeat_period_ms + 16'd1;
        else if (r < 10) it.repeat_period_ms = 0;
        return it;
    endfunction

    task automatic queue_item(in_item_t it);
        cmd_queue.push_back(it);
        items_queued++;
    endtask

    task automatic queue_ticks(int n);
        in_item_t it;
        for (int k = 0; k < n; k++) begin
            it = noise_item();
            it.mode = MODE_TICK;
            queue_item(it);
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (cmd_queue.size() != 0 || s_valid || levels_due.size() != 0);
    endtask

    // Input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) levels_due.push_back(apply_item(s_data));
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    s_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (cmd_queue.size() != 0) begin
                    s_data <= cmd_queue.pop_front();
                    s_valid <= 1'b1;
                    send_gap <= (no_idle || $urandom_range(0, 99) < 55) ? 0 : idle_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin : result_monitor
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (levels_due.size() == 0) begin
                    $display("%0t: result with none pending, expected none actual %p",
                             $time, m_data);
                    mismatches++;
                end else begin
                    want = levels_due.pop_front();
                    if (m_data.led_levels !== want.led_levels) begin
                        $display("%0t: led_levels expected %b actual %b",
                                 $time, want.led_levels, m_data.led_levels);
                        mismatches++;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_data.status);
                        mismatches++;
                    end
                end
            end
            if (rx_stall != 0) begin
                m_ready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end else begin
                m_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 20) rx_stall <= idle_len();
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int scen;
        scen = 0;

        // Directed: field extremes, error paths, nested start failure, count wrap
        queue_item(cmd(MODE_TICK, 2'd0, 16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 8'd0));
        queue_item(cmd(MODE_ON, 2'd0, 16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 8'd0));
        queue_item(cmd(MODE_TOGGLE, 2'd1, 16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 8'd0));
        queue_item(cmd(MODE_OFF, 2'd0, 16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 8'd0));
        queue_item(cmd(MODE_ON, 2'd3, 16'd1, 16'd1, 8'd1, 16'd1, 8'd1, 8'd1));
        // speed error wins over unknown LED
        queue_item(cmd(MODE_ENDLESS, 2'd3, 16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 8'd0));
        queue_item(cmd(MODE_ON_TIME, 2'd0, 16'd0, 16'd5, 8'd1, 16'd5, 8'd1, 8'd1));
        queue_item(cmd(MODE_BLINK, 2'd1, 16'd5, 16'd4, 8'd2, 16'd9, 8'd1, 8'd1));
        queue_item(cmd(MODE_BLINK, 2'd1, 16'd0, 16'd0, 8'd2, 16'd9, 8'd1, 8'd1));
        queue_item(cmd(MODE_REPEAT, 2'd2, 16'd1, 16'd6, 8'd2, 16'd5, 8'd2, 8'd1));
        queue_item(cmd(MODE_REPEAT, 2'd2, 16'd0, 16'd0, 8'd2, 16'd0, 8'd2, 8'd1));
        queue_item(cmd(MODE_ENDLESS, 2'd2, 16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 8'hFF));
        queue_item(cmd(MODE_TICK, 2'd3, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF));
        queue_item(cmd(MODE_STOP_ENDLESS, 2'd2, 16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 8'd0));
        queue_item(cmd(MODE_ON_TIME, 2'd0, 16'hFFFF, 16'd0, 8'd0, 16'd0, 8'd0, 8'd0));
        queue_item(cmd(MODE_TICK, 2'd0, 16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 8'd0));
        queue_item(cmd(MODE_STOP_LED, 2'd0, 16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 8'd0));
        queue_item(cmd(4'hF, 2'd3, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF));
        queue_item(cmd(MODE_STOP_ALL, 2'd3, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF,
                       8'hFF));
        // count of zero runs 256 times
        queue_item(cmd(MODE_BLINK, 2'd1, 16'd1, 16'd1, 8'd0, 16'd0, 8'd0, 8'd0));
        // zero on-time: every nested pulse start is skipped
        queue_item(cmd(MODE_REPEAT, 2'd2, 16'd0, 16'd1, 8'd1, 16'd1, 8'd0, 8'd0));
        queue_item(cmd(MODE_BLINK, 2'd0, 16'd0, 16'd2, 8'd2, 16'd0, 8'd0, 8'd0));
        queue_item(cmd(MODE_ENDLESS, 2'd0, 16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 8'd1));
        queue_item(cmd(MODE_TICK, 2'd0, 16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 8'd0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // hold off until every pending result is back
        wait_idle();
        queue_item(cmd(MODE_STOP_ENDLESS, 2'd0, 16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 8'd0));
        queue_ticks(300);

        while (items_queued < ITEM_GOAL) begin
            while (cmd_queue.size() > 8) @(negedge aclk);
            no_idle = (scen % 6 == 3);
            if (scen == 60) wait_idle();
            repeat ($urandom_range(1, 4)) queue_item(rand_command());
            case ($urandom_range(0, 99)) inside
                [0:89]:  queue_ticks($urandom_range(1, 12));
                [90:97]: queue_ticks($urandom_range(13, 60));
                default: queue_ticks($urandom_range(260, 300));
            endcase
            scen++;
        end

        no_idle = 1'b0;
        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
